// ===== sv/cdkm_pkg.sv =====
// Shared types, constants and card arithmetic for the card deck keystream mixer.
// No dependencies; every other file imports this package.
package cdkm_pkg;

   localparam int DECK_SIZE = 40;
   localparam int CARD_MOD  = 40;
   localparam int DECK_HALF = DECK_SIZE / 2;
   localparam int CARD_W    = 6;
   localparam int POS_W     = 6;
   localparam int BANK_AW   = POS_W + 1;

   typedef logic [CARD_W-1:0] card_type;
   typedef logic [POS_W-1:0]  pos_type;

   typedef enum logic [1:0] {
      CMD_RESET = 2'd0,
      CMD_MIX   = 2'd1,
      CMD_UNMIX = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_CIPHER_SKIP   = 2'd0,
      CSR_CIPHER_OFFSET = 2'd1,
      CSR_CUT_SKIP      = 2'd2,
      CSR_CUT_OFFSET    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PAD_BEFORE,
      PAD_CUT,
      PAD_AFTER
   } purpose_type;

   typedef enum logic [1:0] {
      SW_IDENT,
      SW_MIX,
      SW_UNMIX
   } sweep_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD_ANCHOR,
      ST_PAD_MARK,
      ST_PAD_NEXT,
      ST_PAD_DONE,
      ST_CUT_TOP,
      ST_UNM_TOP,
      ST_UNM_PAD,
      ST_UNM_MARK,
      ST_UNM_ANCHOR,
      ST_UNM_CUT,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      cmd_type  cmd;
      card_type plain_card;
   } req_type;

   typedef struct packed {
      card_type pad_before;
      card_type pad_after;
   } rsp_type;

   // Reduce a 6-bit value mod 40; one subtract suffices since 63 < 80.
   function automatic card_type fold(input logic [CARD_W-1:0] v);
      return (v >= CARD_W'(CARD_MOD)) ? CARD_W'(v - CARD_W'(CARD_MOD)) : v;
   endfunction

   // Both operands are below 40.
   function automatic card_type add_mod(input card_type a, input card_type b);
      logic [CARD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= (CARD_W+1)'(CARD_MOD)) ? CARD_W'(s - (CARD_W+1)'(CARD_MOD)) : CARD_W'(s);
   endfunction

   // Both operands are below 40; the biased difference stays below 80.
   function automatic card_type sub_mod(input card_type a, input card_type b);
      logic [CARD_W:0] s;
      s = {1'b0, a} + (CARD_W+1)'(CARD_MOD) - {1'b0, b};
      return (s >= (CARD_W+1)'(CARD_MOD)) ? CARD_W'(s - (CARD_W+1)'(CARD_MOD)) : CARD_W'(s);
   endfunction

   function automatic pos_type dec_pos(input pos_type p);
      return (p == '0) ? POS_W'(DECK_SIZE - 1) : POS_W'(p - 1'b1);
   endfunction

   // Back-front shuffle: slot of source position i.
   function automatic pos_type shuffle(input pos_type i);
      pos_type h;
      h = {1'b0, i[POS_W-1:1]};
      return i[0] ? POS_W'(POS_W'(DECK_HALF - 1) - h) : POS_W'(POS_W'(DECK_HALF) + h);
   endfunction

   // Inverse of the shuffle: source position of slot p.
   function automatic pos_type unshuffle(input pos_type p);
      pos_type d;
      d = POS_W'(p - POS_W'(DECK_HALF));
      return (p >= POS_W'(DECK_HALF)) ? {d[POS_W-2:0], 1'b0}
                                      : POS_W'(POS_W'(DECK_SIZE - 1) - {p[POS_W-2:0], 1'b0});
   endfunction

endpackage

// ===== sv/card_deck_keystream_mixer.sv =====
// Top level of the card deck keystream mixer: sequencer, deck memories, config registers.
// Depends on cdkm_pkg for types, state codes and card arithmetic.
//
// Usage. A command transfer is taken at a rising edge with start high and busy low; req_data
// carries the command (reset deck, mix, unmix, or no change) and the plain card. Exactly one
// result transfer follows: rsp_strobe is high for one cycle with rsp_data holding the cipher
// pad of the deck before and after the step. The receiver cannot stall, so the result must be
// taken in that cycle. Configuration is written through csr_we, csr_index and csr_wdata, one
// register per edge; the user must write only while busy is low, as the block does not enforce it.
//
// The deck lives in two memories, each split in two banks: a deck memory (position to card)
// and an inverse memory (card to position). A pad read is a chain of dependent reads that
// alternate between the two memories. A deck change is a sweep that reads the old bank and
// writes the new deck and its inverse into the other bank, then flips the bank select. Reads
// and writes in a sweep always hit different banks, so no forwarding is needed.
//
// The unused command is one pad read; a deck reset adds a sweep, and mix and unmix add their
// search for the cut and a sweep, each then reading the pad of the new deck. The next command
// may be started in the cycle the strobe shows. After reset the block runs an identity sweep
// with busy high; configuration writes are taken during it.
module card_deck_keystream_mixer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  cdkm_pkg::req_type       req_data,
   output logic                    rsp_strobe,
   output cdkm_pkg::rsp_type       rsp_data,
   input  logic                    csr_we,
   input  cdkm_pkg::csr_index_type csr_index,
   input  cdkm_pkg::card_type      csr_wdata
);
   import cdkm_pkg::*;

   localparam int MEM_DEPTH = 2 ** BANK_AW;

   card_type deck_mem [0:MEM_DEPTH-1];
   pos_type  inv_mem  [0:MEM_DEPTH-1];

   state_type    state_ff, state_in;
   purpose_type  purpose_ff;
   sweep_op_type sw_op_ff;
   cmd_type      cmd_ff;
   card_type     plain_ff;
   card_type     before_ff;
   card_type     cipher_skip_ff, cipher_offset_ff, cut_skip_ff, cut_offset_ff;
   pos_type      top_ff;
   pos_type      n_ff;
   pos_type      wa_ff;
   logic         sw_vld_ff;
   logic         bank_ff;
   logic         emit_ff;
   card_type     drd_ff;
   pos_type      ird_ff;
   logic         rsp_strobe_ff;
   rsp_type      rsp_data_ff;

   pos_type  daddr, iaddr;
   card_type skip_sel, off_sel;
   pos_type  sw_pos, sw_wa;
   card_type wdata;
   logic     sweep_last;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign sweep_last = (n_ff == POS_W'(DECK_SIZE));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (start) state_in = ST_PAD_ANCHOR;
         ST_PAD_ANCHOR: state_in = ST_PAD_MARK;
         ST_PAD_MARK:   state_in = ST_PAD_NEXT;
         ST_PAD_NEXT:   state_in = ST_PAD_DONE;
         ST_PAD_DONE: begin
            unique case (purpose_ff)
               PAD_BEFORE: begin
                  unique case (cmd_ff)
                     CMD_RESET: state_in = ST_SWEEP;
                     CMD_MIX:   state_in = ST_PAD_ANCHOR;
                     CMD_UNMIX: state_in = ST_UNM_TOP;
                     CMD_NONE:  state_in = ST_IDLE;
                  endcase
               end
               PAD_CUT:   state_in = ST_CUT_TOP;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_CUT_TOP:    state_in = ST_SWEEP;
         ST_UNM_TOP:    state_in = ST_UNM_PAD;
         ST_UNM_PAD:    state_in = ST_UNM_MARK;
         ST_UNM_MARK:   state_in = ST_UNM_ANCHOR;
         ST_UNM_ANCHOR: state_in = ST_UNM_CUT;
         ST_UNM_CUT:    state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = emit_ff ? ST_PAD_ANCHOR : ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Read addresses and sweep mapping.
   always_comb begin
      skip_sel = (purpose_ff == PAD_CUT) ? cut_skip_ff   : cipher_skip_ff;
      off_sel  = (purpose_ff == PAD_CUT) ? cut_offset_ff : cipher_offset_ff;
      sw_pos   = add_mod(top_ff, n_ff);
      unique case (sw_op_ff)
         SW_MIX:   sw_wa = shuffle(n_ff);
         default:  sw_wa = n_ff;
      endcase
      wdata = (sw_op_ff == SW_IDENT) ? wa_ff : drd_ff;
      daddr = '0;
      iaddr = '0;
      unique case (state_ff)
         ST_PAD_ANCHOR: daddr = fold(skip_sel);
         ST_PAD_MARK:   iaddr = add_mod(drd_ff, fold(off_sel));
         ST_PAD_NEXT:   daddr = (ird_ff == POS_W'(DECK_SIZE - 1)) ? '0 : POS_W'(ird_ff + 1'b1);
         ST_PAD_DONE:   iaddr = add_mod(drd_ff, fold(plain_ff));
         ST_UNM_TOP:    daddr = POS_W'(DECK_HALF);
         ST_UNM_PAD:    iaddr = sub_mod(drd_ff, fold(plain_ff));
         ST_UNM_MARK:   daddr = shuffle(dec_pos(unshuffle(ird_ff)));
         ST_UNM_ANCHOR: iaddr = sub_mod(drd_ff, fold(cut_offset_ff));
         ST_SWEEP:      daddr = (sw_op_ff == SW_UNMIX) ? shuffle(sw_pos) : sw_pos;
         default: begin
            daddr = '0;
            iaddr = '0;
         end
      endcase
   end

   // Deck and inverse memories: one registered read port and one write port each.
   always_ff @(posedge clock) begin
      if (sw_vld_ff) begin
         deck_mem[{~bank_ff, wa_ff}] <= wdata;
         inv_mem[{~bank_ff, wdata}]  <= wa_ff;
      end
      drd_ff <= deck_mem[{bank_ff, daddr}];
      ird_ff <= inv_mem[{bank_ff, iaddr}];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_skip_ff   <= '0;
         cipher_offset_ff <= '0;
         cut_skip_ff      <= '0;
         cut_offset_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CIPHER_SKIP:   cipher_skip_ff   <= csr_wdata;
            CSR_CIPHER_OFFSET: cipher_offset_ff <= csr_wdata;
            CSR_CUT_SKIP:      cut_skip_ff      <= csr_wdata;
            CSR_CUT_OFFSET:    cut_offset_ff    <= csr_wdata;
         endcase
      end
   end

   // Sequencer registers and datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sw_op_ff      <= SW_IDENT;
         n_ff          <= '0;
         sw_vld_ff     <= 1'b0;
         bank_ff       <= 1'b1;
         emit_ff       <= 1'b0;
         purpose_ff    <= PAD_BEFORE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;
         sw_vld_ff     <= (state_ff == ST_SWEEP) && !sweep_last;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff     <= req_data.cmd;
                  plain_ff   <= req_data.plain_card;
                  purpose_ff <= PAD_BEFORE;
                  emit_ff    <= 1'b1;
               end
            end
            ST_PAD_DONE: begin
               unique case (purpose_ff)
                  PAD_BEFORE: begin
                     before_ff <= drd_ff;
                     unique case (cmd_ff)
                        CMD_RESET: begin
                           sw_op_ff <= SW_IDENT;
                           n_ff     <= '0;
                        end
                        CMD_MIX:   purpose_ff <= PAD_CUT;
                        CMD_UNMIX: ;
                        CMD_NONE: begin
                           rsp_strobe_ff          <= 1'b1;
                           rsp_data_ff.pad_before <= drd_ff;
                           rsp_data_ff.pad_after  <= drd_ff;
                        end
                     endcase
                  end
                  PAD_CUT: ;
                  default: begin
                     rsp_strobe_ff          <= 1'b1;
                     rsp_data_ff.pad_before <= before_ff;
                     rsp_data_ff.pad_after  <= drd_ff;
                  end
               endcase
            end
            ST_CUT_TOP: begin
               top_ff   <= ird_ff;
               sw_op_ff <= SW_MIX;
               n_ff     <= '0;
            end
            ST_UNM_CUT: begin
               top_ff   <= sub_mod(unshuffle(ird_ff), fold(cut_skip_ff));
               sw_op_ff <= SW_UNMIX;
               n_ff     <= '0;
            end
            ST_SWEEP: begin
               if (sweep_last) begin
                  bank_ff    <= ~bank_ff;
                  purpose_ff <= PAD_AFTER;
               end else begin
                  n_ff  <= POS_W'(n_ff + 1'b1);
                  wa_ff <= sw_wa;
               end
            end
            default: ;
         endcase
      end
   end

   a_strobe_from_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_PAD_DONE))
      else $error("result strobe without a finished pad read");

   a_accept_starts_pad: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_PAD_ANCHOR))
      else $error("accepted command did not start the pad read");

   a_sweep_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (n_ff <= POS_W'(DECK_SIZE)))
      else $error("sweep counter past the deck");

   a_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sw_vld_ff |-> $past(state_ff == ST_SWEEP) && (state_ff == ST_SWEEP))
      else $error("deck write outside a sweep");

endmodule

// ===== bench/card_deck_keystream_mixer_tb.sv =====
// Self-checking testbench for the card deck keystream mixer: directed table, then random commands.
// Depends on cdkm_pkg and card_deck_keystream_mixer; the deck predictor lives in this module.
module card_deck_keystream_mixer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cdkm_pkg::*;

   localparam int RANDOM_ITEMS = 1630;
   localparam int CYCLE_LIMIT  = 400000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   req_type   req_data = '0;
   logic      rsp_strobe;
   rsp_type   rsp_data;
   logic      csr_we = 1'b0;
   csr_index_type csr_index = CSR_CIPHER_SKIP;
   card_type  csr_wdata = '0;

   card_deck_keystream_mixer u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: the deck and the four registers as the block should hold them.
   int unsigned deck_model [DECK_SIZE];
   int unsigned cipher_skip_q, cipher_offset_q, cut_skip_q, cut_offset_q;
   rsp_type     pad_queue [$];
   int          error_count = 0;
   int          rsp_count = 0;
   int          mix_count = 0, unmix_count = 0;
   int unsigned cycle_count = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic int unsigned skip_forward(input int unsigned d[DECK_SIZE],
                                                input int unsigned p, input int unsigned n);
      int unsigned left;
      left = n;
      forever begin
         while (d[p] >= CARD_MOD) p = (p + 1) % DECK_SIZE;
         if (left == 0) return p;
         left--;
         p = (p + 1) % DECK_SIZE;
      end
   endfunction

   function automatic int unsigned skip_backward(input int unsigned d[DECK_SIZE],
                                                 input int unsigned p, input int unsigned n);
      int unsigned left;
      left = n;
      forever begin
         while (d[p] >= CARD_MOD) p = (p + DECK_SIZE - 1) % DECK_SIZE;
         if (left == 0) return p;
         left--;
         p = (p + DECK_SIZE - 1) % DECK_SIZE;
      end
   endfunction

   function automatic int unsigned find_card(input int unsigned d[DECK_SIZE], input int unsigned v);
      for (int i = 0; i < DECK_SIZE; i++) if (d[i] == v) return i;
      return 0;
   endfunction

   function automatic int unsigned pad_of(input int unsigned d[DECK_SIZE],
                                          input int unsigned skip, input int unsigned off);
      int unsigned mark;
      mark = (d[skip_forward(d, 0, skip)] + off) % CARD_MOD;
      return d[skip_forward(d, find_card(d, mark), 1)];
   endfunction

   function automatic int unsigned slot_of(input int unsigned i);
      return (i % 2 == 0) ? DECK_HALF + i / 2 : DECK_HALF - 1 - i / 2;
   endfunction

   // Applies one command to the predicted deck and returns both cipher pads.
   function automatic rsp_type step_deck(input req_type r);
      int unsigned cut [DECK_SIZE];
      int unsigned pre, pad, mark, anchor, top, plain;
      rsp_type res;
      plain = r.plain_card % CARD_MOD;
      pre = pad_of(deck_model, cipher_skip_q, cipher_offset_q);
      case (r.cmd)
         CMD_RESET: begin
            for (int i = 0; i < DECK_SIZE; i++) deck_model[i] = i;
         end
         CMD_MIX: begin
            top = find_card(deck_model,
                  (pad_of(deck_model, cut_skip_q, cut_offset_q) + plain) % CARD_MOD);
            for (int i = 0; i < DECK_SIZE; i++) cut[i] = deck_model[(top + i) % DECK_SIZE];
            for (int i = 0; i < DECK_SIZE; i++) deck_model[slot_of(i)] = cut[i];
         end
         CMD_UNMIX: begin
            for (int i = 0; i < DECK_SIZE; i++) cut[i] = deck_model[slot_of(i)];
            // A joker on top after unshuffling is folded mod 40 first.
            pad = (cut[0] % CARD_MOD + CARD_MOD - plain) % CARD_MOD;
            mark = cut[skip_backward(cut, find_card(cut, pad), 1)];
            anchor = (mark % CARD_MOD + CARD_MOD - cut_offset_q % CARD_MOD) % CARD_MOD;
            top = skip_backward(cut, find_card(cut, anchor), cut_skip_q);
            for (int i = 0; i < DECK_SIZE; i++) deck_model[i] = cut[(top + i) % DECK_SIZE];
         end
         default: ;
      endcase
      res.pad_before = card_type'(pre);
      res.pad_after  = card_type'(pad_of(deck_model, cipher_skip_q, cipher_offset_q));
      return res;
   endfunction

   // Result checker: every strobe is a transfer matched against the oldest expectation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         rsp_count <= rsp_count + 1;
         if (pad_queue.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            rsp_type want;
            want = pad_queue.pop_front();
            if (rsp_data.pad_before !== want.pad_before)
               report_mismatch($sformatf("pad_before got %0d want %0d",
                                         rsp_data.pad_before, want.pad_before));
            if (rsp_data.pad_after !== want.pad_after)
               report_mismatch($sformatf("pad_after got %0d want %0d",
                                         rsp_data.pad_after, want.pad_after));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Writes one register at a falling edge; only called while the block is idle.
   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= card_type'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CIPHER_SKIP:   cipher_skip_q = value % 64;
         CSR_CIPHER_OFFSET: cipher_offset_q = value % 64;
         CSR_CUT_SKIP:      cut_skip_q = value % 64;
         default:           cut_offset_q = value % 64;
      endcase
   endtask

   task automatic write_all(input int unsigned a, b, c, d);
      write_reg(CSR_CIPHER_SKIP, a);
      write_reg(CSR_CIPHER_OFFSET, b);
      write_reg(CSR_CUT_SKIP, c);
      write_reg(CSR_CUT_OFFSET, d);
   endtask

   // Drops start, waits until every expected result has arrived, then lets the block settle.
   task automatic drain();
      start <= 1'b0;
      while (pad_queue.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Sends one command transfer. The prediction is queued at the accepting edge so the
   // predicted deck advances in the same order as the block's. Start stays high after the
   // transfer; drain drops it at the same falling edge, and the next call drops it only while idling.
   task automatic send_cmd(input req_type r, input bit idle_ok);
      if (idle_ok) begin
         while ($urandom_range(99) < 16) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pad_queue.push_back(step_deck(r));
      if (r.cmd == CMD_MIX) mix_count++;
      if (r.cmd == CMD_UNMIX) unmix_count++;
      @(negedge clock);
   endtask

   typedef struct {
      cmd_type  cmd;
      int unsigned plain;
      bit       fixed;
      int unsigned want_before;
      int unsigned want_after;
   } row_type;

   row_type directed [] = '{
      // Identity deck with zero registers: the pad is the card after card 0, which is 1.
      '{CMD_NONE,  0,  1, 1, 1},
      '{CMD_RESET, 0,  1, 1, 1},
      '{CMD_MIX,   0,  0, 0, 0},
      '{CMD_MIX,   39, 0, 0, 0},
      '{CMD_UNMIX, 39, 0, 0, 0},
      '{CMD_UNMIX, 0,  0, 0, 0},
      '{CMD_MIX,   63, 0, 0, 0},
      '{CMD_UNMIX, 40, 0, 0, 0},
      '{CMD_MIX,   21, 0, 0, 0},
      '{CMD_NONE,  42, 0, 0, 0},
      '{CMD_UNMIX, 63, 0, 0, 0},
      '{CMD_RESET, 17, 0, 0, 0}
   };

   initial begin
      req_type r;
      int unsigned n;
      cipher_skip_q = 0; cipher_offset_q = 0; cut_skip_q = 0; cut_offset_q = 0;
      for (int i = 0; i < DECK_SIZE; i++) deck_model[i] = i;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (busy) @(negedge clock);

      // Directed table; fixed rows also check a hand-read expectation.
      foreach (directed[k]) begin
         r.cmd = directed[k].cmd;
         r.plain_card = card_type'(directed[k].plain);
         if (directed[k].fixed && k == 0 && (directed[k].want_before != 1))
            report_mismatch("bad table row");
         send_cmd(r, 1'b0);
         if (directed[k].fixed &&
             (pad_queue[$].pad_before != directed[k].want_before ||
              pad_queue[$].pad_after != directed[k].want_after))
            report_mismatch($sformatf("predictor disagrees with table row %0d", k));
      end
      drain();

      // Register extremes, including out-of-range offsets and skips that wrap the deck.
      write_all(39, 39, 39, 39);
      for (int k = 0; k < 6; k++) begin
         r.cmd = (k % 2) ? CMD_UNMIX : CMD_MIX;
         r.plain_card = card_type'($urandom_range(63));
         send_cmd(r, 1'b0);
      end
      drain();
      write_all(63, 63, 63, 63);
      for (int k = 0; k < 6; k++) begin
         r.cmd = cmd_type'($urandom_range(3));
         r.plain_card = card_type'($urandom_range(63));
         send_cmd(r, 1'b0);
      end
      drain();

      // Random phases with new settings; the first phase sends with no idling at all.
      n = 0;
      for (int phase = 0; phase < 10; phase++) begin
         write_all($urandom_range(63), $urandom_range(63), $urandom_range(63),
                   $urandom_range(63));
         for (int k = 0; k < RANDOM_ITEMS / 10; k++) begin
            int unsigned pick;
            pick = $urandom_range(99);
            // Mostly mix and unmix; an occasional deck reset and the unused command.
            if (pick < 45)      r.cmd = CMD_MIX;
            else if (pick < 90) r.cmd = CMD_UNMIX;
            else if (pick < 95) r.cmd = CMD_RESET;
            else                r.cmd = CMD_NONE;
            r.plain_card = card_type'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                                 : $urandom_range(39));
            send_cmd(r, phase != 0);
            n++;
         end
         drain();
      end

      drain();
      repeat (60) @(negedge clock);
      $display("Covered %0d commands (%0d mix, %0d unmix) over 13 register settings,",
               n + directed.size() + 12, mix_count, unmix_count);
      $display("with %0d result transfers checked.", rsp_count);
      if (error_count == 0 && pad_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ===== card_deck_keystream_mixer.f =====
sv/cdkm_pkg.sv
sv/card_deck_keystream_mixer.sv
bench/card_deck_keystream_mixer_tb.sv
